// ===== hdl/mild_pkg.sv =====
package mild_pkg;

  localparam int unsigned HEADER_BYTES = 10;
  localparam int unsigned HCNT_W = 4;

  localparam logic [31:0] MAGIC_RESET   = 32'h4642_4542;
  localparam logic [31:0] MAX_LEN_RESET = 32'd65536;

  localparam logic CFG_HEADER_MAGIC    = 1'b0;
  localparam logic CFG_MAX_BODY_LENGTH = 1'b1;

  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_RESP = 2'd1;
  localparam logic [1:0] ACT_NEW  = 2'd2;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_WAIT   = 2'd2;
  localparam logic [1:0] PH_CLOSED = 2'd3;

  localparam logic KIND_BODY   = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  localparam logic ERR_MAGIC  = 1'b0;
  localparam logic ERR_LENGTH = 1'b1;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  body_byte;
    logic [15:0] event_id;
    logic        last_byte;
    logic        error_code;
  } out_word_t;

  typedef struct packed {
    logic [31:0] header_magic;
    logic [31:0] max_body_length;
  } cfg_t;

endpackage

// ===== hdl/mild_parser.sv =====
module mild_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  mild_pkg::in_word_t word,
  input  mild_pkg::cfg_t     cfg,
  output logic               res_valid,
  output mild_pkg::out_word_t res
);
  import mild_pkg::*;

  logic [1:0]        phase_r, phase_nxt;
  logic [HCNT_W-1:0] hcnt_r, hcnt_nxt;
  logic [31:0]       magic_r, magic_nxt;
  logic [15:0]       eid_r, eid_nxt;
  logic [31:0]       len_r, len_nxt;
  logic [31:0]       bcnt_r, bcnt_nxt;

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    magic_nxt = magic_r;
    eid_nxt   = eid_r;
    len_nxt   = len_r;
    bcnt_nxt  = bcnt_r;
    res_valid = 1'b0;
    res       = '0;
    res.event_id = eid_r;
    case (word.action)
      ACT_NEW: begin
        phase_nxt = PH_HEADER;
        hcnt_nxt  = '0;
        magic_nxt = '0;
        eid_nxt   = '0;
        len_nxt   = '0;
        bcnt_nxt  = '0;
      end
      ACT_RESP: begin
        if (phase_r != PH_CLOSED) begin
          phase_nxt = PH_HEADER;
          hcnt_nxt  = '0;
          magic_nxt = '0;
          eid_nxt   = '0;
          len_nxt   = '0;
          bcnt_nxt  = '0;
        end
      end
      ACT_BYTE: begin
        case (phase_r)
          PH_HEADER: begin
            case (hcnt_r)
              4'd0, 4'd1, 4'd2, 4'd3: magic_nxt = {magic_r[23:0], word.rx_byte};
              4'd4: eid_nxt[7:0]   = word.rx_byte;
              4'd5: eid_nxt[15:8]  = word.rx_byte;
              4'd6: len_nxt[7:0]   = len_r[7:0]   | word.rx_byte;
              4'd7: len_nxt[15:8]  = len_r[15:8]  | word.rx_byte;
              4'd8: len_nxt[23:16] = len_r[23:16] | word.rx_byte;
              4'd9: len_nxt[31:24] = len_r[31:24] | word.rx_byte;
              default: ;
            endcase
            hcnt_nxt = hcnt_r + 1'b1;
            if (hcnt_nxt == HCNT_W'(HEADER_BYTES)) begin
              if (magic_nxt != cfg.header_magic) begin
                phase_nxt        = PH_CLOSED;
                res_valid        = 1'b1;
                res.result_kind  = KIND_REJECT;
                res.error_code   = ERR_MAGIC;
              end else if (len_nxt == '0 || len_nxt > cfg.max_body_length) begin
                phase_nxt        = PH_CLOSED;
                res_valid        = 1'b1;
                res.result_kind  = KIND_REJECT;
                res.error_code   = ERR_LENGTH;
              end else begin
                phase_nxt = PH_BODY;
                bcnt_nxt  = '0;
              end
            end
          end
          PH_BODY: begin
            bcnt_nxt        = bcnt_r + 32'd1;
            res_valid       = 1'b1;
            res.result_kind = KIND_BODY;
            res.body_byte   = word.rx_byte;
            res.last_byte   = (bcnt_nxt == len_r);
            if (bcnt_nxt == len_r) begin
              phase_nxt = PH_WAIT;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hcnt_r  <= '0;
      magic_r <= '0;
      eid_r   <= '0;
      len_r   <= '0;
      bcnt_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      magic_r <= magic_nxt;
      eid_r   <= eid_nxt;
      len_r   <= len_nxt;
      bcnt_r  <= bcnt_nxt;
    end
  end

endmodule

// ===== hdl/magic_id_length_deframer_core.sv =====
// channel | direction | handshake            | payload
// in_     | input     | in_valid / in_ready   | in_data   (action, rx_byte)
// out_    | output    | out_valid / out_ready | out_data  (kind, byte, id, last, error)
// cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// One word per cycle sustained while the output is not stalled; an accepted word is
// registered in the input register, passes the parser, and its result is registered in the
// result register, which drives out_data.
// rst_n is synchronous; it clears the valid flags of both stages and the parser state, and loads the config registers.
// A stalled result holds the result register; the input register still takes one word.
module magic_id_length_deframer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mild_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mild_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import mild_pkg::*;

  cfg_t      cfg_r;
  logic      inv_r;
  in_word_t  inw_r;
  logic      outv_r;
  out_word_t outw_r;
  logic      step;
  logic      res_valid;
  out_word_t res;

  assign step     = inv_r && (!outv_r || out_ready);
  assign in_ready = !inv_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_magic    <= MAGIC_RESET;
      cfg_r.max_body_length <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER_MAGIC:    cfg_r.header_magic    <= cfg_wdata;
        CFG_MAX_BODY_LENGTH: cfg_r.max_body_length <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (in_ready) begin
      inv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      inw_r <= in_data;
    end
  end

  mild_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .word      (inw_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outv_r <= 1'b0;
    end else if (!outv_r || out_ready) begin
      outv_r <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      outw_r <= res;
    end
  end

  assign out_valid = outv_r;
  assign out_data  = outw_r;

endmodule

// ===== hdl/mild_checker.sv =====
module mild_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mild_pkg::out_word_t out_data
);
  import mild_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_REJECT |->
      out_data.last_byte == 1'b0 && out_data.body_byte == 8'd0)
    else $error("rejection carries body fields");

  a_body_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_BODY |-> out_data.error_code == 1'b0)
    else $error("body word carries an error code");

  // with no word taken in now nor in the past sample of the handshake, and the output free, no new result appears
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && in_ready) && !$past(in_valid && in_ready) |=> !out_valid)
    else $error("result without an input word");

endmodule

bind magic_id_length_deframer_core mild_checker u_mild_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
